### rtl/core/psw_pkg.sv
package psw_pkg;

	localparam int TIME_WIDTH_DEF = 64;

	localparam logic [2:0] OP_RESTART  = 3'd0;
	localparam logic [2:0] OP_QUERY    = 3'd1;
	localparam logic [2:0] OP_CHECK    = 3'd2;
	localparam logic [2:0] OP_CONS_ONE = 3'd3;
	localparam logic [2:0] OP_CONS_ALL = 3'd4;
	localparam logic [2:0] OP_PAUSE    = 3'd5;
	localparam logic [2:0] OP_RESUME   = 3'd6;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] now_ticks;
	} in_item_t;

	typedef struct packed {
		logic [63:0] elapsed_ticks;
		logic        has_elapsed;
		logic [31:0] intervals_consumed;
		logic        is_paused;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DIV,
		ST_WRITE
	} state_t;

endpackage

### rtl/core/psw_div.sv
module psw_div import psw_pkg::*; #(
	parameter int W = TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/core/pausable_interval_stopwatch_top.sv
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we                 cfg_wdata (interval_ticks)
// in       in         in_valid / in_ready    in_item (op, now_ticks)
// out      out        out_valid / out_ready  out_item (elapsed, flag, count, paused)
//
// An item passes the states IDLE, where it is accepted, SCAN, a bit-serial pass over
// all time registers, APPLY for the op and WRITE to load the output register, which
// waits while that register stalls. Consume-all with an elapsed, nonzero interval also
// passes DIV, the radix-2 divider, between APPLY and WRITE. One item is worked on at a
// time; the next is taken once the result sits in the output register, even while that
// register stalls.
// Reset clears the timer state and the interval at once; no clearing pass.
module pausable_interval_stopwatch_top import psw_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int TW = TIME_WIDTH;
	localparam int CW = $clog2(TW);

	state_t state_q, state_d;

	logic [TW-1:0] now_q, start_q, ded_q, pmark_q, int_q;
	logic [TW-1:0] e_q, alt_q, sum_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]    op_q;
	logic          paused_q, hi_nz_q, int_nz_q;
	logic          b1_q, c2_q, b3_q, b4_q, c5_q, c6_q, gt_q;
	logic          has_q;
	logic [31:0]   cons_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic accept, scan_last, has, div_go, slot_free, out_load;
	logic div_done;
	logic [TW-1:0] div_quot, div_rem;
	logic [63:0]   quot_ext;

	logic n, s, p, d, k, x, dnew, e1, e, nb1, nc2, nb3, nb4;

	assign accept    = in_valid && in_ready;
	assign scan_last = (cnt_q == CW'(TW - 1));
	assign has       = gt_q && !hi_nz_q;
	assign slot_free = !out_valid_q || out_ready;
	assign quot_ext  = 64'(div_quot);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_APPLY;
			ST_APPLY: state_d = div_go ? ST_DIV : ST_WRITE;
			ST_DIV:   if (div_done) state_d = ST_WRITE;
			ST_WRITE: if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_go   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_APPLY: div_go = (op_q == OP_CONS_ALL) && has && int_nz_q;
			ST_WRITE: out_load = slot_free;
			default:  ;
		endcase
	end

	// one bit of every time register per cycle, LSB first
	always_comb begin
		n    = now_q[0];
		s    = start_q[0];
		p    = pmark_q[0];
		d    = ded_q[0];
		k    = int_q[0];
		x    = n ^ p ^ b1_q;
		nb1  = (~n & p) | (~(n ^ p) & b1_q);
		dnew = paused_q ? (d ^ x ^ c2_q) : d;
		nc2  = (d & x) | (d & c2_q) | (x & c2_q);
		e1   = n ^ s ^ b3_q;
		nb3  = (~n & s) | (~(n ^ s) & b3_q);
		e    = e1 ^ dnew ^ b4_q;
		nb4  = (~e1 & dnew) | (~(e1 ^ dnew) & b4_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			int_q       <= '0;
			hi_nz_q     <= 1'b0;
			int_nz_q    <= 1'b0;
			start_q     <= '0;
			ded_q       <= '0;
			pmark_q     <= '0;
			paused_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				int_q    <= cfg_wdata[TW-1:0];
				hi_nz_q  <= (cfg_wdata >> TW) != 64'd0;
				int_nz_q <= cfg_wdata != 64'd0;
			end
			if (accept) begin
				cnt_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				cnt_q   <= cnt_q + CW'(1);
				start_q <= {s, start_q[TW-1:1]};
				ded_q   <= {dnew, ded_q[TW-1:1]};
				pmark_q <= {paused_q ? n : p, pmark_q[TW-1:1]};
				int_q   <= {k, int_q[TW-1:1]};
			end
			if (state_q == ST_APPLY) begin
				case (op_q)
					OP_RESTART: begin
						start_q <= now_q;
						ded_q   <= '0;
					end
					OP_CHECK: begin
						if (has) begin
							start_q <= now_q;
							ded_q   <= '0;
						end
					end
					OP_CONS_ONE: begin
						if (has) ded_q <= alt_q;
					end
					OP_PAUSE: begin
						paused_q <= 1'b1;
						pmark_q  <= now_q;
					end
					OP_RESUME: paused_q <= 1'b0;
					default: ;
				endcase
			end
			// add count * interval, which is elapsed minus the remainder
			if (state_q == ST_DIV && div_done) begin
				ded_q <= sum_q - div_rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_item.op;
			now_q <= in_item.now_ticks[TW-1:0];
			b1_q  <= 1'b0;
			c2_q  <= 1'b0;
			b3_q  <= 1'b0;
			b4_q  <= 1'b0;
			c5_q  <= 1'b0;
			c6_q  <= 1'b0;
			gt_q  <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			now_q <= {n, now_q[TW-1:1]};
			b1_q  <= nb1;
			c2_q  <= nc2;
			b3_q  <= nb3;
			b4_q  <= nb4;
			e_q   <= {e, e_q[TW-1:1]};
			alt_q <= {dnew ^ k ^ c5_q, alt_q[TW-1:1]};
			c5_q  <= (dnew & k) | (dnew & c5_q) | (k & c5_q);
			sum_q <= {dnew ^ e ^ c6_q, sum_q[TW-1:1]};
			c6_q  <= (dnew & e) | (dnew & c6_q) | (e & c6_q);
			if (e != k) gt_q <= e & ~k;
		end
		if (state_q == ST_APPLY) begin
			has_q  <= has;
			cons_q <= (op_q == OP_CONS_ONE && has) ? 32'd1 : 32'd0;
		end
		if (state_q == ST_DIV && div_done) begin
			cons_q <= (quot_ext[63:32] != 32'd0) ? 32'hFFFF_FFFF : quot_ext[31:0];
		end
		if (out_load) begin
			out_q.elapsed_ticks      <= 64'(e_q);
			out_q.has_elapsed        <= has_q;
			out_q.intervals_consumed <= cons_q;
			out_q.is_paused          <= paused_q;
		end
	end

	psw_div #(
		.W(TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (e_q),
		.divisor  (int_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import psw_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 140;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	pausable_interval_stopwatch_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// stopwatch state as predicted from the accepted items
	logic [63:0] interval_cfg = '0;
	logic [63:0] mark_start = '0;
	logic [63:0] ticks_deducted = '0;
	logic [63:0] mark_pause = '0;
	logic paused_now = 1'b0;

	out_item_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	int ready_mode = 0;
	int mode_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[pausable_interval_stopwatch_top] ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic out_item_t stopwatch_step(input logic [2:0] op_code,
			input logic [63:0] now_val);
		out_item_t res;
		logic [63:0] elapsed;
		logic [63:0] count;
		logic has;
		logic [31:0] consumed;
		consumed = '0;
		if (paused_now) begin
			ticks_deducted = ticks_deducted + (now_val - mark_pause);
			mark_pause = now_val;
		end
		elapsed = now_val - mark_start - ticks_deducted;
		has = elapsed > interval_cfg;
		case (op_code)
			OP_RESTART: begin
				mark_start = now_val;
				ticks_deducted = '0;
			end
			OP_CHECK: begin
				if (has) begin
					mark_start = now_val;
					ticks_deducted = '0;
				end
			end
			OP_CONS_ONE: begin
				if (has) begin
					ticks_deducted = ticks_deducted + interval_cfg;
					consumed = 32'd1;
				end
			end
			OP_CONS_ALL: begin
				if (has && interval_cfg != 0) begin
					count = elapsed / interval_cfg;
					ticks_deducted = ticks_deducted + interval_cfg * count;
					consumed = (count > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : count[31:0];
				end
			end
			OP_PAUSE: begin
				paused_now = 1'b1;
				mark_pause = now_val;
			end
			OP_RESUME: paused_now = 1'b0;
			default: ;
		endcase
		res.elapsed_ticks = elapsed;
		res.has_elapsed = has;
		res.intervals_consumed = consumed;
		res.is_paused = paused_now;
		return res;
	endfunction

	task automatic send_item(input logic [2:0] op_code, input logic [63:0] now_val);
		in_item_t item;
		int gap;
		item.op = op_code;
		item.now_ticks = now_val;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(stopwatch_step(op_code, now_val));
		burst_left--;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_interval(input logic [63:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		interval_cfg = value;
		@(posedge clk);
	endtask

	// receiver: hold out_ready on a pattern that changes mode now and then
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: begin
					if ($urandom_range(0, 9) == 0) begin
						stall_left = $urandom_range(10, 150);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual %h", $time, out_item);
			end else begin
				want = expected_results.pop_front();
				check_field("elapsed_ticks", want.elapsed_ticks, out_item.elapsed_ticks);
				check_field("has_elapsed", 64'(want.has_elapsed), 64'(out_item.has_elapsed));
				check_field("intervals_consumed", 64'(want.intervals_consumed),
					64'(out_item.intervals_consumed));
				check_field("is_paused", 64'(want.is_paused), 64'(out_item.is_paused));
			end
		end
	end

	task automatic test_reset_defaults();
		send_item(OP_QUERY, 64'd0);
		send_item(OP_QUERY, '1);
		send_item(OP_CONS_ALL, 64'd5000);
	endtask

	task automatic test_each_op();
		write_interval(64'd100);
		send_item(OP_RESTART, 64'd1000);
		send_item(OP_QUERY, 64'd1050);
		send_item(OP_CONS_ONE, 64'd1250);
		send_item(OP_CONS_ALL, 64'd1400);
		send_item(OP_CHECK, 64'd1450);
		send_item(OP_PAUSE, 64'd1500);
		send_item(OP_QUERY, 64'd1600);
		send_item(OP_PAUSE, 64'd1700);
		send_item(OP_RESUME, 64'd1800);
		send_item(OP_UNUSED, 64'd1900);
		send_item(OP_CHECK, 64'd1950);
	endtask

	task automatic test_interval_extremes();
		write_interval('1);
		send_item(OP_RESTART, 64'd0);
		send_item(OP_CONS_ALL, '1);
		write_interval(64'd1);
		send_item(OP_RESTART, 64'hFFFF_FFFF_FFFF_FF00);
		send_item(OP_CONS_ALL, 64'h0000_0100_0000_0000);
		send_item(OP_CONS_ONE, 64'h0000_0100_0000_0001);
	endtask

	function automatic logic [2:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return OP_RESTART;
		if (r < 25) return OP_QUERY;
		if (r < 38) return OP_CHECK;
		if (r < 58) return OP_CONS_ONE;
		if (r < 75) return OP_CONS_ALL;
		if (r < 85) return OP_PAUSE;
		if (r < 95) return OP_RESUME;
		return OP_UNUSED;
	endfunction

	function automatic logic [63:0] advance_now(input logic [63:0] cur);
		if ($urandom_range(0, 19) == 0)
			return rand64();
		if ($urandom_range(0, 1) == 0 && interval_cfg != 0 && interval_cfg != '1)
			return cur + (interval_cfg * 64'($urandom_range(0, 300))) / 100;
		return cur + (rand64() >> $urandom_range(0, 63));
	endfunction

	task automatic test_random();
		logic [63:0] intervals[6];
		logic [63:0] cur;
		intervals[0] = 64'd0;
		intervals[1] = 64'd1;
		intervals[2] = '1;
		intervals[3] = 64'($urandom_range(2, 65535));
		intervals[4] = rand64() >> 24;
		intervals[5] = rand64() >> $urandom_range(0, 40);
		for (int p = 0; p < 6; p++) begin
			write_interval(intervals[p]);
			cur = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom);
			for (int n = 0; n < 110; n++) begin
				cur = advance_now(cur);
				send_item(pick_op(), cur);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_each_op();
		test_interval_extremes();
		test_random();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d items expected, actual none", $time, expected_results.size());
		end
		if (errors == 0) begin
			$display("[pausable_interval_stopwatch_top] OK");
		end else begin
			$display("[pausable_interval_stopwatch_top] ERROR");
		end
		$finish;
	end

endmodule
